>>> hdl/rro_pkg.sv
`default_nettype none

package rro_pkg;

  // Field widths
  localparam int COORD_WIDTH  = 12;
  localparam int RADIUS_WIDTH = 8;
  localparam int COLOR_WIDTH  = 16;

  // Arc step counters hold 0 .. r + 1
  localparam int STEP_WIDTH = RADIUS_WIDTH + 1;
  // Signed midpoint decision term
  localparam int DEC_WIDTH  = RADIUS_WIDTH + 4;
  // Width that holds both a span and twice the radius
  localparam int LEN_WIDTH  = (COORD_WIDTH > RADIUS_WIDTH + 1) ? COORD_WIDTH : RADIUS_WIDTH + 1;

  // Operation codes of an input word
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PRIM_DOT   = 2'd0,
    PRIM_HLINE = 2'd1,
    PRIM_VLINE = 2'd2
  } prim_e;

  typedef struct packed {
    logic                    operation;
    logic [COORD_WIDTH-1:0]  x_left;
    logic [COORD_WIDTH-1:0]  y_top;
    logic [COORD_WIDTH-1:0]  rect_width;
    logic [COORD_WIDTH-1:0]  rect_height;
    logic [RADIUS_WIDTH-1:0] corner_radius;
    logic [COLOR_WIDTH-1:0]  pixel_color;
  } in_word_t;

  typedef struct packed {
    prim_e                  prim_kind;
    logic [COORD_WIDTH-1:0] out_x;
    logic [COORD_WIDTH-1:0] out_y;
    logic [COORD_WIDTH-1:0] line_length;
    logic [COLOR_WIDTH-1:0] out_color;
    logic                   last_of_batch;
    logic                   shape_done;
  } out_word_t;

  // One batch of primitives handed from the front to the back
  typedef struct packed {
    logic                    lines;
    logic [COORD_WIDTH-1:0]  origin_x;
    logic [COORD_WIDTH-1:0]  origin_y;
    logic [COORD_WIDTH-1:0]  span_w;
    logic [COORD_WIDTH-1:0]  span_h;
    logic [RADIUS_WIDTH-1:0] radius;
    logic [STEP_WIDTH-1:0]   step_x;
    logic [STEP_WIDTH-1:0]   step_y;
    logic [COLOR_WIDTH-1:0]  color;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_stat_t;

endpackage

`default_nettype wire

>>> hdl/rro_front.sv
`default_nettype none

module rro_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rro_pkg::in_word_t in_word_i,
  input  wire logic              in_accept_i,
  output logic                   push_o,
  output rro_pkg::job_t          job_o
);

  localparam int CW = rro_pkg::COORD_WIDTH;
  localparam int RW = rro_pkg::RADIUS_WIDTH;
  localparam int SW = rro_pkg::STEP_WIDTH;
  localparam int DW = rro_pkg::DEC_WIDTH;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ARC,
    PH_LINES
  } phase_e;

  phase_e                   phase_q;
  logic [CW-1:0]            ox_q, oy_q, w_q, h_q;
  logic [RW-1:0]            r_q;
  logic [rro_pkg::COLOR_WIDTH-1:0] color_q;
  logic [SW-1:0]            sx_q, sy_q;
  logic [DW-1:0]            dec_q;

  logic                     start;
  logic [CW-1:0]            cur_ox, cur_oy, cur_w, cur_h;
  logic [RW-1:0]            cur_r;
  logic [rro_pkg::COLOR_WIDTH-1:0] cur_color;
  logic [SW-1:0]            cur_x, cur_y, x_d, y_d;
  logic [DW-1:0]            cur_dec, dec_d;
  logic signed [DW:0]       x_ext, y_ext, inc, dec_sum;
  logic                     arcs_end;

  assign start = (in_word_i.operation == rro_pkg::OP_START);

  // Pick the fresh geometry on a start word, the stored one otherwise
  always_comb begin
    if (start) begin
      cur_ox    = in_word_i.x_left;
      cur_oy    = in_word_i.y_top;
      cur_w     = in_word_i.rect_width;
      cur_h     = in_word_i.rect_height;
      cur_r     = in_word_i.corner_radius;
      cur_color = in_word_i.pixel_color;
      cur_x     = '0;
      cur_y     = SW'(in_word_i.corner_radius);
      cur_dec   = DW'(3) - (DW'(in_word_i.corner_radius) << 1);
    end else begin
      cur_ox    = ox_q;
      cur_oy    = oy_q;
      cur_w     = w_q;
      cur_h     = h_q;
      cur_r     = r_q;
      cur_color = color_q;
      cur_x     = sx_q;
      cur_y     = sy_q;
      cur_dec   = dec_q;
    end
  end

  // Advance the midpoint iteration by one step
  always_comb begin
    x_ext = $signed({{(DW + 1 - SW){1'b0}}, cur_x});
    y_ext = $signed({{(DW + 1 - SW){1'b0}}, cur_y});
    if (cur_dec[DW-1]) begin
      inc = (x_ext <<< 2) + $signed((DW + 1)'(6));
      y_d = cur_y;
    end else begin
      inc = ((x_ext - y_ext) <<< 2) + $signed((DW + 1)'(10));
      y_d = (cur_y != '0) ? cur_y - SW'(1) : cur_y;
    end
    dec_sum  = $signed({cur_dec[DW-1], cur_dec}) + inc;
    dec_d    = dec_sum[DW-1:0];
    x_d      = cur_x + SW'(1);
    arcs_end = (cur_r == '0) || (x_d > y_d);
  end

  // Hand a batch to the queue whenever the word produces results
  always_comb begin
    push_o         = in_accept_i && (start || phase_q == PH_ARC || phase_q == PH_LINES);
    job_o.lines    = !start && (phase_q == PH_LINES);
    job_o.origin_x = cur_ox;
    job_o.origin_y = cur_oy;
    job_o.span_w   = cur_w;
    job_o.span_h   = cur_h;
    job_o.radius   = cur_r;
    job_o.step_x   = cur_x;
    job_o.step_y   = cur_y;
    job_o.color    = cur_color;
  end

  // Hold geometry and phase, advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ox_q    <= '0;
      oy_q    <= '0;
      w_q     <= '0;
      h_q     <= '0;
      r_q     <= '0;
      color_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      dec_q   <= '0;
    end else if (in_accept_i) begin
      if (start) begin
        ox_q    <= cur_ox;
        oy_q    <= cur_oy;
        w_q     <= cur_w;
        h_q     <= cur_h;
        r_q     <= cur_r;
        color_q <= cur_color;
      end
      if (start || phase_q == PH_ARC) begin
        sx_q    <= x_d;
        sy_q    <= y_d;
        dec_q   <= dec_d;
        phase_q <= arcs_end ? PH_LINES : PH_ARC;
      end else if (phase_q == PH_LINES) begin
        phase_q <= PH_IDLE;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rro_queue.sv
`default_nettype none

module rro_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rro_pkg::job_t job_i,
  input  wire logic          pop_i,
  output rro_pkg::job_t      job_o,
  output rro_pkg::queue_stat_t stat_o
);

  rro_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign job_o            = mem_q[rd_ptr_q];
  assign stat_o.full      = (count_q == 2'd2);
  assign stat_o.not_empty = (count_q != 2'd0);

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rro_back.sv
`default_nettype none

module rro_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rro_pkg::job_t      job_i,
  input  wire logic               job_avail_i,
  output logic                    pop_o,
  output rro_pkg::out_word_t      out_word_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i
);

  localparam int CW = rro_pkg::COORD_WIDTH;
  localparam int LW = rro_pkg::LEN_WIDTH;

  rro_pkg::job_t      job_q;
  logic               job_valid_q;
  logic [2:0]         beat_q;
  rro_pkg::out_word_t out_q;
  logic               out_valid_q;

  logic               emit, last_beat;
  logic [CW-1:0]      r_c, lx, rx, ty, by, px, py, wl, hl;
  logic [LW-1:0]      twice_r, span_w, span_h;
  logic               left_side, top_side;
  rro_pkg::out_word_t prim;

  assign emit      = job_valid_q && (!out_valid_q || !out_stall_i);
  assign last_beat = job_q.lines ? (beat_q == 3'd3) : (beat_q == 3'd7);
  assign pop_o     = job_avail_i && (!job_valid_q || (emit && last_beat));

  // Corner centers and saturated line lengths
  always_comb begin
    r_c     = CW'(job_q.radius);
    lx      = job_q.origin_x + r_c;
    ty      = job_q.origin_y + r_c;
    rx      = job_q.origin_x + job_q.span_w - r_c;
    by      = job_q.origin_y + job_q.span_h - r_c;
    twice_r = LW'(job_q.radius) << 1;
    span_w  = LW'(job_q.span_w);
    span_h  = LW'(job_q.span_h);
    wl      = (twice_r > span_w) ? '0 : CW'(span_w - twice_r);
    hl      = (twice_r > span_h) ? '0 : CW'(span_h - twice_r);
  end

  // Build the primitive for the current beat
  always_comb begin
    px        = beat_q[0] ? CW'(job_q.step_y) : CW'(job_q.step_x);
    py        = beat_q[0] ? CW'(job_q.step_x) : CW'(job_q.step_y);
    left_side = (beat_q[2] == beat_q[1]);
    top_side  = !beat_q[2];

    prim.out_color     = job_q.color;
    prim.last_of_batch = last_beat;
    prim.shape_done    = job_q.lines;
    if (job_q.lines) begin
      case (beat_q[1:0])
        2'd0: begin
          prim.prim_kind   = rro_pkg::PRIM_HLINE;
          prim.out_x       = lx;
          prim.out_y       = job_q.origin_y;
          prim.line_length = wl;
        end
        2'd1: begin
          prim.prim_kind   = rro_pkg::PRIM_HLINE;
          prim.out_x       = lx;
          prim.out_y       = job_q.origin_y + job_q.span_h;
          prim.line_length = wl;
        end
        2'd2: begin
          prim.prim_kind   = rro_pkg::PRIM_VLINE;
          prim.out_x       = job_q.origin_x;
          prim.out_y       = ty;
          prim.line_length = hl;
        end
        default: begin
          prim.prim_kind   = rro_pkg::PRIM_VLINE;
          prim.out_x       = job_q.origin_x + job_q.span_w;
          prim.out_y       = ty;
          prim.line_length = hl;
        end
      endcase
    end else begin
      prim.prim_kind   = rro_pkg::PRIM_DOT;
      prim.out_x       = left_side ? lx - px : rx + px;
      prim.out_y       = top_side ? ty - py : by + py;
      prim.line_length = '0;
    end
  end

  // Load batches, step beats, hold the output word while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      beat_q      <= 3'd0;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      out_q       <= '0;
    end else begin
      if (pop_o) begin
        job_q       <= job_i;
        job_valid_q <= 1'b1;
        beat_q      <= 3'd0;
      end else if (emit) begin
        if (last_beat) begin
          job_valid_q <= 1'b0;
          beat_q      <= 3'd0;
        end else begin
          beat_q <= beat_q + 3'd1;
        end
      end
      if (emit) begin
        out_q       <= prim;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/rounded_rect_outline_generator.sv
`default_nettype none
// The first primitive of a word passes through the batch queue, the back end's batch register and its output register.
// The back end emits one primitive per cycle while out_stall_i is low; an arc word yields 8 dots
//   and the line word 4 lines; a two-entry batch queue lets the front take words while the back drains.
// A step word with no shape in progress yields no primitive.
// Reset (rst_ni, asynchronous, active low) empties the queue, drops any output word and
//   returns the shape phase to idle.
module rounded_rect_outline_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rro_pkg::in_word_t  in_word_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output rro_pkg::out_word_t      out_word_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i
);

  rro_pkg::job_t        push_job, pop_job;
  rro_pkg::queue_stat_t q_stat;
  logic                 q_push, q_pop, in_accept;

  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  rro_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .in_accept_i (in_accept),
    .push_o      (q_push),
    .job_o       (push_job)
  );

  rro_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  rro_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_avail_i (q_stat.not_empty),
    .pop_o       (q_pop),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_stat.full))
    else $error("batch pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && !q_stat.not_empty))
    else $error("batch popped from empty queue");

  // Line words complete the shape, dots never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.shape_done == (out_word_o.prim_kind != rro_pkg::PRIM_DOT)))
    else $error("shape_done does not match primitive kind");

  // Dots carry zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.prim_kind == rro_pkg::PRIM_DOT |-> out_word_o.line_length == '0)
    else $error("dot with nonzero length");

endmodule

`default_nettype wire
